// ----- sv/slcg_pkg.sv -----
// shared types and constants of the shuffled lcg random generator
package slcg_pkg;

   localparam int unsigned WORD_W          = 32;
   localparam int unsigned TABLE_DEPTH_DEF = 128;

   // lcg step x = x * LCG_MULT + 1
   localparam logic [WORD_W-1:0] LCG_MULT = 32'd69069;

   // selector step constants
   localparam logic [WORD_W-1:0] SEL_KEY   = 32'd123456;
   localparam int unsigned       SEL_MOD_W = 20;
   localparam logic [SEL_MOD_W-1:0] SEL_MOD = 20'd1000003;

   // reciprocal of the selector modulus, scaled by 2^SEL_SHIFT, rounded down
   localparam int unsigned SEL_SHIFT   = 40;
   localparam int unsigned SEL_RECIP_W = 21;
   localparam logic [SEL_RECIP_W-1:0] SEL_RECIP =
      SEL_RECIP_W'((64'd1 << SEL_SHIFT) / 64'd1000003);
   localparam int unsigned SEL_Q_W = 13;

   // table index reduction: remainder magnitude times 2^IDX_SHIFT / depth
   localparam int unsigned IDX_SHIFT   = 21;
   localparam int unsigned IDX_RECIP_W = 21;

   // operation codes
   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   localparam logic [WORD_W-1:0] RESET_SEED = 32'd1;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_SEL_MUL,
      ST_SEL_FIX,
      ST_IDX_MUL,
      ST_IDX_FIX,
      ST_DELIVER
   } slcg_state_type;

endpackage

// ----- sv/slcg_req_if.sv -----
// request channel: operation and seed word
interface slcg_req_if;
   import slcg_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [WORD_W-1:0] seed_value;

   modport source (output valid, output op, output seed_value, input ready);
   modport sink   (input valid, input op, input seed_value, output ready);
endinterface

// ----- sv/slcg_rsp_if.sv -----
// response channel: one random word per draw
interface slcg_rsp_if;
   import slcg_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ----- sv/slcg_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module slcg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/shuffled_lcg_random_generator.sv -----
// top level of the shuffled lcg random word generator
//
// usage
//   req_ch carries one transaction per operation: op selects a reseed or a draw,
//   seed_value is the seed for a reseed and is ignored on a draw.
//   rsp_ch carries one transaction per draw with the selected table word;
//   a reseed gives no response.
// timing
//   a draw goes from acceptance to rsp_ch.valid through the selector remainder
//   (reciprocal multiply, then correction), the table index reduction (likewise,
//   the correction also issuing the table memory read), and a delivery step that
//   hands out the read word and writes back the refill word. the next request is
//   taken in the cycle after delivery, so a draw is finished before another
//   request is taken. a reseed refills the table; the fill writes one table entry
//   per cycle through the single memory write port.
// reset
//   synchronous reset starts a fill as if seeded with 1; req_ch.ready stays
//   low until the table is full.
// stalls
//   the response sits in an output register; a request can be taken while it
//   waits, and a later draw waits in its last step until the register is free.
module shuffled_lcg_random_generator #(
   parameter int unsigned TABLE_DEPTH = slcg_pkg::TABLE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   slcg_req_if.sink    req_ch,
   slcg_rsp_if.source  rsp_ch
);
   import slcg_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [SEL_MOD_W-1:0] DEPTH_M   = SEL_MOD_W'(TABLE_DEPTH);
   localparam logic [IDX_RECIP_W-1:0] IDX_RECIP =
      IDX_RECIP_W'((64'd1 << IDX_SHIFT) / TABLE_DEPTH);

   // control and state registers
   slcg_state_type state_ff, state_in;
   logic [WORD_W-1:0]    lcg_ff, lcg_in;
   logic [WORD_W-1:0]    sel_ff, sel_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [WORD_W-1:0]    mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [SEL_Q_W-1:0]   q1_ff, q1_in;
   logic [SEL_MOD_W-1:0] rem_ff, rem_in;
   logic [SEL_MOD_W-1:0] q2_ff, q2_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [WORD_W-1:0]    word_ff, word_in;

   // memory port
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;

   // arithmetic
   logic [WORD_W-1:0]    lcg_next;
   logic [WORD_W-1:0]    sel_shift;
   logic [WORD_W-1:0]    sel_mag;
   logic [52:0]          prod1;
   logic [32:0]          qd1;
   logic [WORD_W-1:0]    diff1;
   logic [SEL_MOD_W:0]   diff1_n;
   logic [SEL_MOD_W-1:0] rem_fix;
   logic [40:0]          prod2;
   logic [32:0]          qd2;
   logic [SEL_MOD_W-1:0] diff2;
   logic [SEL_MOD_W-1:0] idx_fix;
   logic                 out_free;

   slcg_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (lcg_next),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // lcg step, 32 x 17 bit multiply
   assign lcg_next = lcg_ff * LCG_MULT + 32'd1;

   // selector shift with key mixing when the old value was negative
   assign sel_shift = {sel_ff[WORD_W-2:0], 1'b0} ^ (sel_ff[WORD_W-1] ? SEL_KEY : '0);
   assign sel_mag   = sel_shift[WORD_W-1] ? (~sel_shift + 32'd1) : sel_shift;

   // quotient estimate by reciprocal, low by at most one
   assign prod1 = 53'(mag_ff) * 53'(SEL_RECIP);
   assign qd1   = 33'(q1_ff) * 33'(SEL_MOD);
   assign diff1 = mag_ff - qd1[WORD_W-1:0];
   assign diff1_n = diff1[SEL_MOD_W:0];
   assign rem_fix = (diff1_n >= {1'b0, SEL_MOD}) ? SEL_MOD_W'(diff1_n - {1'b0, SEL_MOD})
                                                  : diff1_n[SEL_MOD_W-1:0];

   // |selector| mod table depth, same reciprocal scheme
   assign prod2   = 41'(rem_ff) * 41'(IDX_RECIP);
   assign qd2     = 33'(q2_ff) * 33'(DEPTH_M);
   assign diff2   = rem_ff - qd2[SEL_MOD_W-1:0];
   assign idx_fix = (diff2 >= DEPTH_M) ? (diff2 - DEPTH_M) : diff2;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      lcg_in       = lcg_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      q1_in        = q1_ff;
      rem_in       = rem_ff;
      q2_in        = q2_ff;
      idx_in       = idx_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = idx_fix[IDX_W-1:0];

      unique case (state_ff)
         ST_FILL: begin
            // one table entry per cycle from the lcg
            ram_wr_en = 1'b1;
            lcg_in    = lcg_next;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.op == OP_RESEED) begin
                  lcg_in   = req_ch.seed_value;
                  sel_in   = req_ch.seed_value;
                  cnt_in   = '0;
                  state_in = ST_FILL;
               end else begin
                  mag_in   = sel_mag;
                  neg_in   = sel_shift[WORD_W-1];
                  state_in = ST_SEL_MUL;
               end
            end
         end
         ST_SEL_MUL: begin
            q1_in    = prod1[52:SEL_SHIFT];
            state_in = ST_SEL_FIX;
         end
         ST_SEL_FIX: begin
            // remainder keeps the sign of the dividend
            rem_in   = rem_fix;
            sel_in   = neg_ff ? (~32'(rem_fix) + 32'd1) : 32'(rem_fix);
            state_in = ST_IDX_MUL;
         end
         ST_IDX_MUL: begin
            q2_in    = prod2[40:IDX_SHIFT];
            state_in = ST_IDX_FIX;
         end
         ST_IDX_FIX: begin
            ram_rd_en = 1'b1;
            idx_in    = idx_fix[IDX_W-1:0];
            state_in  = ST_DELIVER;
         end
         ST_DELIVER: begin
            // hand out the entry and refill it once the output slot is free
            ram_wr_addr = idx_ff;
            if (out_free) begin
               ram_wr_en    = 1'b1;
               lcg_in       = lcg_next;
               word_in      = ram_rd_data;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         lcg_ff       <= RESET_SEED;
         sel_ff       <= RESET_SEED;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lcg_ff       <= lcg_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      q1_ff   <= q1_in;
      rem_ff  <= rem_in;
      q2_ff   <= q2_in;
      idx_ff  <= idx_in;
      word_ff <= word_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.random_word = word_ff;

endmodule

// ----- bench/shuffled_lcg_random_generator_test.sv -----
`timescale 1ns / 1ps
// testbench of the shuffled lcg random generator: predicts every drawn word and checks it

class shuffle_predictor;
   localparam int unsigned DEPTH = slcg_pkg::TABLE_DEPTH_DEF;

   logic [31:0] lcg_word;
   logic [31:0] selector_word;
   logic [31:0] table_words [DEPTH];
   logic [31:0] expected_words [$];
   int unsigned mismatches;
   int unsigned failures;

   function new();
      mismatches = 0;
      failures   = 0;
      reseed(slcg_pkg::RESET_SEED);
   endfunction

   function logic [31:0] lcg_step();
      lcg_word = lcg_word * slcg_pkg::LCG_MULT + 32'd1;
      return lcg_word;
   endfunction

   function void reseed(logic [31:0] seed);
      lcg_word      = seed;
      selector_word = seed;
      for (int i = 0; i < DEPTH; i++) begin
         table_words[i] = lcg_step();
      end
   endfunction

   // selector step, then table index from the remainder magnitude
   function int unsigned draw_index();
      logic [31:0] shifted;
      int          remainder;
      shifted = selector_word << 1;
      if (selector_word[31]) begin
         shifted = shifted ^ slcg_pkg::SEL_KEY;
      end
      remainder     = $signed(shifted) % int'(slcg_pkg::SEL_MOD);
      selector_word = remainder;
      if (remainder < 0) begin
         remainder = -remainder;
      end
      return int'(remainder) % int'(DEPTH);
   endfunction

   function void note_request(logic op, logic [31:0] seed);
      int unsigned idx;
      if (op == slcg_pkg::OP_RESEED) begin
         reseed(seed);
      end else begin
         idx = draw_index();
         expected_words.push_back(table_words[idx]);
         table_words[idx] = lcg_step();
      end
   endfunction

   function void check_word(logic [31:0] word);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
         failures++;
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected random_word %h", $realtime, word);
         end
         return;
      end
      want = expected_words.pop_front();
      if (word !== want) begin
         failures++;
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: random_word expected %h actual %h", $realtime, want, word);
         end
      end
   endfunction

   function int unsigned pending();
      return expected_words.size();
   endfunction
endclass

module shuffled_lcg_random_generator_test;
   import slcg_pkg::*;

   localparam int unsigned IDLE_PERCENT = 36;
   localparam int unsigned RANDOM_ITEMS = 1500;
   // no transaction for this long means the block is stuck
   localparam int unsigned STALL_LIMIT  = 4000;
   // a reseed gives no response, so allow a full refill after the last word
   localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH_DEF + 20;

   logic        clock;
   logic        reset;
   bit          steady;        // set during the stretch with no idling
   int unsigned quiet_cycles = 0;
   logic [31:0] seed;

   shuffle_predictor book = new();

   slcg_req_if req_ch ();
   slcg_rsp_if rsp_ch ();

   shuffled_lcg_random_generator u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random idle decision shared by both sides
   function automatic bit take_break();
      return !steady && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // offer one transaction, with random gaps ahead of it, and wait for acceptance
   task automatic send_request(input logic op, input logic [31:0] seed_word);
      while (take_break()) begin
         req_ch.valid      <= 1'b0;
         req_ch.op         <= 1'($urandom);
         req_ch.seed_value <= $urandom;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.seed_value <= seed_word;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // monitor: values read here are the ones before the edge, since all drives
   // are nonblocking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            book.check_word(rsp_ch.random_word);
         end
         if (req_ch.valid && req_ch.ready) begin
            book.note_request(req_ch.op, req_ch.seed_value);
         end
         // watchdog on cycles without any transaction
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      // response side back pressure
      rsp_ch.ready <= !take_break();
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      steady       = 1'b0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_DRAW;
      req_ch.seed_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // draws straight after reset use the table filled from seed one
      repeat (6) send_request(OP_DRAW, $urandom);
      // seed zero: the selector stays at zero and every draw takes entry zero
      send_request(OP_RESEED, 32'h0000_0000);
      repeat (3) send_request(OP_DRAW, $urandom);
      // all ones: negative selector from the start
      send_request(OP_RESEED, 32'hffff_ffff);
      repeat (3) send_request(OP_DRAW, $urandom);
      // most negative selector, shift drops the sign bit entirely
      send_request(OP_RESEED, 32'h8000_0000);
      repeat (2) send_request(OP_DRAW, $urandom);
      send_request(OP_RESEED, 32'h7fff_ffff);
      repeat (2) send_request(OP_DRAW, $urandom);
      // back to back reseeds, only the second one counts
      send_request(OP_RESEED, 32'h1234_5678);
      send_request(OP_RESEED, RESET_SEED);
      repeat (2) send_request(OP_DRAW, $urandom);

      // random part: mostly draws, occasional reseeds, some with extreme seeds
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 600 && n < 900);
         if ($urandom_range(99) < 10) begin
            case ($urandom_range(7))
               0:       seed = 32'h0000_0000;
               1:       seed = 32'hffff_ffff;
               2:       seed = 32'h8000_0000;
               3:       seed = 32'h7fff_ffff;
               default: seed = $urandom;
            endcase
            send_request(OP_RESEED, seed);
         end else begin
            send_request(OP_DRAW, $urandom);
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // let every outstanding word arrive, then wait DRAIN_CYCLES so a last reseed can finish
      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (book.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
